/* sv/tgaks_pkg.sv */
// Package for the two-generation aging key set.
// Holds the shared constants, the controller state type and the token that runs along the cell row.
package tgaks_pkg;

    localparam int GEN_CAPACITY_DEFAULT = 512;
    localparam int KEY_W = 64;
    localparam int LIMIT_W = 9;
    localparam logic [LIMIT_W-1:0] AGE_LIMIT_RESET = 9'd500;
    localparam logic [KEY_W-1:0] KEY_FORCE_BITS = 64'h3;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_CHECK = 2'd1,
        CMD_AGE   = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        TOK_INSERT   = 2'd0,
        TOK_TAKE_CUR = 2'd1,
        TOK_TAKE_OLD = 2'd2
    } tok_op_t;

    typedef struct packed {
        logic             valid;
        tok_op_t          op;
        logic             done;
        logic [KEY_W-1:0] key;
    } token_t;

    typedef enum logic [1:0] {
        ST_IDLE      = 2'd0,
        ST_SWEEP_CUR = 2'd1,
        ST_SWEEP_OLD = 2'd2,
        ST_FINISH    = 2'd3
    } state_t;

endpackage

/* sv/tgaks_cell.sv */
// One slot of the key row: a current and an old key with their valid bits.
// Depends on tgaks_pkg for the token type.
module tgaks_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rotate,
    input  tgaks_pkg::token_t tok_in,
    output tgaks_pkg::token_t tok_out
);
    import tgaks_pkg::*;

    logic [KEY_W-1:0] cur_key_reg;
    logic [KEY_W-1:0] old_key_reg;
    logic             cur_valid_reg;
    logic             old_valid_reg;
    logic             tok_valid_reg;
    tok_op_t          tok_op_reg;
    logic             tok_done_reg;
    logic [KEY_W-1:0] tok_key_reg;
    logic             act;

    always_comb
    begin
        act = 1'b0;
        if (tok_in.valid && !tok_in.done)
        begin
            unique case (tok_in.op)
                TOK_INSERT:   act = !cur_valid_reg;
                TOK_TAKE_CUR: act = cur_valid_reg && (cur_key_reg == tok_in.key);
                TOK_TAKE_OLD: act = old_valid_reg && (old_key_reg == tok_in.key);
                default:      act = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            old_valid_reg <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in.valid;
            if (rotate)
            begin
                old_valid_reg <= cur_valid_reg;
                cur_valid_reg <= 1'b0;
            end
            else if (act)
            begin
                unique case (tok_in.op)
                    TOK_INSERT:   cur_valid_reg <= 1'b1;
                    TOK_TAKE_CUR: cur_valid_reg <= 1'b0;
                    TOK_TAKE_OLD: old_valid_reg <= 1'b0;
                    default:      cur_valid_reg <= cur_valid_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tok_op_reg   <= tok_in.op;
        tok_key_reg  <= tok_in.key;
        tok_done_reg <= tok_in.done || act;
        if (rotate)
        begin
            old_key_reg <= cur_key_reg;
        end
        else if (act && (tok_in.op == TOK_INSERT))
        begin
            cur_key_reg <= tok_in.key;
        end
    end

    always_comb
    begin
        tok_out.valid = tok_valid_reg;
        tok_out.op    = tok_op_reg;
        tok_out.done  = tok_done_reg;
        tok_out.key   = tok_key_reg;
    end

endmodule

/* sv/tgaks_ctrl.sv */
// Sequencer of the key set: takes requests, launches tokens into the cell row and builds results.
// Depends on tgaks_pkg; drives the rotate line and the head of the row.
module tgaks_ctrl #(
    parameter int GEN_CAPACITY = tgaks_pkg::GEN_CAPACITY_DEFAULT
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  tgaks_pkg::cmd_t                    in_cmd,
    input  logic [tgaks_pkg::KEY_W-1:0]        in_hash,
    input  logic                               in_gossip,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               out_found,
    output logic                               out_aged,
    input  logic [tgaks_pkg::LIMIT_W-1:0]      age_limit,
    output logic                               rotate,
    output tgaks_pkg::token_t                  tok_head,
    input  tgaks_pkg::token_t                  tok_tail
);
    import tgaks_pkg::*;

    localparam int CW = $clog2(GEN_CAPACITY + 1);
    localparam int MW = (CW > LIMIT_W) ? CW : LIMIT_W;

    state_t           state_reg;
    state_t           state_next;
    logic [CW-1:0]    count_reg;
    logic [KEY_W-1:0] key_reg;
    tok_op_t          op_reg;
    logic             launch_reg;
    logic             launch_next;
    logic             found_reg;
    logic             aged_reg;
    logic             out_valid_reg;
    logic             out_found_reg;
    logic             out_aged_reg;
    logic             accept;
    logic             full;
    logic             over_limit;
    logic             tail_seen;
    logic             out_free;

    assign accept     = in_valid && in_ready;
    assign full       = (count_reg == CW'(GEN_CAPACITY));
    assign over_limit = (MW'(count_reg) > MW'(age_limit));
    assign tail_seen  = tok_tail.valid;
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next  = state_reg;
        launch_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_gossip && (in_cmd == CMD_ADD || in_cmd == CMD_CHECK))
                    begin
                        state_next  = ST_SWEEP_CUR;
                        launch_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SWEEP_CUR:
            begin
                if (tail_seen)
                begin
                    if (op_reg == TOK_TAKE_CUR && !tok_tail.done)
                    begin
                        state_next  = ST_SWEEP_OLD;
                        launch_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SWEEP_OLD:
            begin
                if (tail_seen)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        rotate   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                rotate = in_valid && ((in_cmd == CMD_AGE) ||
                         (in_cmd == CMD_ADD && in_gossip && full));
            end
            ST_SWEEP_CUR:
            begin
                rotate = tail_seen && (op_reg == TOK_INSERT) && over_limit;
            end
            ST_SWEEP_OLD: rotate = 1'b0;
            ST_FINISH:    rotate = 1'b0;
            default:      rotate = 1'b0;
        endcase
    end

    always_comb
    begin
        tok_head.valid = launch_reg;
        tok_head.op    = op_reg;
        tok_head.done  = 1'b0;
        tok_head.key   = key_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            if (state_reg == ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (in_cmd == CMD_AGE)
                        begin
                            count_reg <= '0;
                        end
                        else if (in_gossip && in_cmd == CMD_ADD)
                        begin
                            count_reg <= full ? CW'(1) : count_reg + CW'(1);
                        end
                    end
                end
                ST_SWEEP_CUR:
                begin
                    if (tail_seen)
                    begin
                        if (op_reg == TOK_INSERT)
                        begin
                            if (over_limit)
                            begin
                                count_reg <= '0;
                            end
                        end
                        else if (tok_tail.done)
                        begin
                            count_reg <= count_reg - CW'(1);
                        end
                    end
                end
                ST_SWEEP_OLD: count_reg <= count_reg;
                ST_FINISH:    count_reg <= count_reg;
                default:      count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_reg   <= in_hash | KEY_FORCE_BITS;
                    op_reg    <= (in_cmd == CMD_ADD) ? TOK_INSERT : TOK_TAKE_CUR;
                    found_reg <= 1'b0;
                    aged_reg  <= (in_cmd == CMD_AGE) ||
                                 (in_cmd == CMD_ADD && in_gossip && full);
                end
            end
            ST_SWEEP_CUR:
            begin
                if (tail_seen)
                begin
                    if (op_reg == TOK_INSERT)
                    begin
                        aged_reg <= aged_reg || over_limit;
                    end
                    else if (tok_tail.done)
                    begin
                        found_reg <= 1'b1;
                    end
                    else
                    begin
                        op_reg <= TOK_TAKE_OLD;
                    end
                end
            end
            ST_SWEEP_OLD:
            begin
                if (tail_seen)
                begin
                    found_reg <= tok_tail.done;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_found_reg <= found_reg;
                    out_aged_reg  <= aged_reg;
                end
            end
            default: found_reg <= found_reg;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_found = out_found_reg;
    assign out_aged  = out_aged_reg;

endmodule

/* sv/two_generation_aging_key_set.sv */
// Top level of the two-generation aging key set: sequencer plus a row of key cells.
// Depends on tgaks_pkg, tgaks_ctrl and tgaks_cell.
//
// A duplicate filter for gossip keys. Requests enter on the s_axis channel: tdata carries the
// 64-bit message hash, tuser carries the command and the gossip flag. Each request gives one
// result on m_axis: bit 0 of tdata is found, bit 1 is aged.
// The age limit is written through the cfg channel, which is always ready.
// Every slot of a generation lives in one cell of a row of GEN_CAPACITY cells. Add and check
// send a token down the row, one cell per clock; the first cell that can serve it does so.
// Age, ignored and non-gossip requests go straight to the finish state. Add sends one token
// down the row; check sends one through the current generation and, on a miss there, a second
// through the old generation. The length of the cell row sets how long add and check take.
// One request is worked on at a time; the next is taken as soon as the result is registered,
// even while the receiver has not yet taken it. A stalled receiver holds the result and
// blocks only the completion of the following request.
// Reset clears all valid bits and the entry count and loads the age limit with 500.
module two_generation_aging_key_set #(
    parameter int GEN_CAPACITY = tgaks_pkg::GEN_CAPACITY_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [63:0]                   s_axis_tdata,  // message_hash
    input  logic [2:0]                    s_axis_tuser,  // cmd[1:0], is_gossip[2]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,  // found[0], aged[1], zero[7:2]
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tgaks_pkg::LIMIT_W-1:0] cfg_data
);
    import tgaks_pkg::*;

    logic [LIMIT_W-1:0] age_limit_reg;
    logic               rotate;
    logic               found;
    logic               aged;
    token_t             tok [GEN_CAPACITY+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_limit_reg <= AGE_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            age_limit_reg <= cfg_data;
        end
    end

    tgaks_ctrl #(
        .GEN_CAPACITY(GEN_CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (cmd_t'(s_axis_tuser[1:0])),
        .in_hash   (s_axis_tdata),
        .in_gossip (s_axis_tuser[2]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_found (found),
        .out_aged  (aged),
        .age_limit (age_limit_reg),
        .rotate    (rotate),
        .tok_head  (tok[0]),
        .tok_tail  (tok[GEN_CAPACITY])
    );

    for (genvar i = 0; i < GEN_CAPACITY; i++)
    begin : g_cell
        tgaks_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .rotate  (rotate),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    assign m_axis_tdata = {6'b0, aged, found};

endmodule

/* sv/tgaks_checker.sv */
// Port-level checks for the two-generation aging key set, bound to the top level.
// Depends only on the top level's ports.
module tgaks_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    // A check request never rotates, so a result never shows both flags.
    a_found_not_aged: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("found and aged both set");

    // One request at a time: input is closed the cycle after a request is taken.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while busy");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:2] == 6'b0))
        else $error("result padding not zero");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind two_generation_aging_key_set tgaks_checker u_tgaks_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* test/tgaks_checker.sv */
// Checker for the two-generation aging key set: watches the request, result and limit channels.
// Keeps its own model of both generations and compares every result; depends on tgaks_pkg.
module tgaks_scoreboard
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    output int          errors,
    output int          pending
);
    import tgaks_pkg::*;

    localparam int SLOTS = GEN_CAPACITY_DEFAULT;

    typedef struct packed {
        logic found;
        logic aged;
    } verdict_t;

    logic [KEY_W-1:0]   cur_key [SLOTS];
    logic [KEY_W-1:0]   old_key [SLOTS];
    bit                 cur_used [SLOTS];
    bit                 old_used [SLOTS];
    int                 cur_count;
    logic [LIMIT_W-1:0] limit;
    verdict_t           verdicts[$];

    function automatic void rotate_gens();
        old_key = cur_key;
        old_used = cur_used;
        foreach (cur_used[i]) cur_used[i] = 0;
        cur_count = 0;
    endfunction

    function automatic bit store_key(logic [KEY_W-1:0] key);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!cur_used[i])
            begin
                cur_used[i] = 1;
                cur_key[i] = key;
                cur_count++;
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic verdict_t dedup_step(cmd_t cmd, logic [KEY_W-1:0] hash, logic gossip);
        logic [KEY_W-1:0] key;
        verdict_t v;
        bit hit;
        key = hash | KEY_FORCE_BITS;
        v = '0;
        hit = 0;
        case (cmd)
            CMD_ADD:
                if (gossip)
                begin
                    if (!store_key(key))
                    begin
                        rotate_gens();
                        v.aged = 1;
                        void'(store_key(key));
                    end
                    if (cur_count > limit)
                    begin
                        rotate_gens();
                        v.aged = 1;
                    end
                end
            CMD_CHECK:
                if (gossip)
                begin
                    for (int i = 0; i < SLOTS && !hit; i++)
                    begin
                        if (cur_used[i] && cur_key[i] == key)
                        begin
                            cur_used[i] = 0;
                            cur_count--;
                            hit = 1;
                        end
                    end
                    for (int i = 0; i < SLOTS && !hit; i++)
                    begin
                        if (old_used[i] && old_key[i] == key)
                        begin
                            old_used[i] = 0;
                            hit = 1;
                        end
                    end
                    v.found = hit;
                end
            CMD_AGE:
            begin
                rotate_gens();
                v.aged = 1;
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic report(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            foreach (cur_used[i])
            begin
                cur_used[i] = 0;
                old_used[i] = 0;
            end
            cur_count = 0;
            limit = AGE_LIMIT_RESET;
            verdicts.delete();
            pending = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (verdicts.size() == 0)
                    report("unexpected result", m_axis_tdata, 8'h0);
                else
                begin
                    want = verdicts.pop_front();
                    if (m_axis_tdata[0] !== want.found)
                        report("found", {7'b0, m_axis_tdata[0]}, {7'b0, want.found});
                    if (m_axis_tdata[1] !== want.aged)
                        report("aged", {7'b0, m_axis_tdata[1]}, {7'b0, want.aged});
                    if (m_axis_tdata[7:2] !== 6'b0)
                        report("padding", m_axis_tdata, 8'h0);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                verdicts.push_back(dedup_step(cmd_t'(s_axis_tuser[1:0]), s_axis_tdata,
                                              s_axis_tuser[2]));
            if (cfg_valid && cfg_ready)
                limit = cfg_data;
            pending = verdicts.size();
        end
    end

endmodule

/* test/tb_top.sv */
// Testbench top for the two-generation aging key set: clock, reset, stimulus and verdict.
// Depends on tgaks_pkg, tgaks_scoreboard and the block under test.
module tb_top;
    import tgaks_pkg::*;

    localparam longint CYCLE_LIMIT = 20000000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  cfg_data;
    int          errors;
    int          pending;
    longint      cycles;
    int          burst_left;
    int          gap_left;
    logic [63:0] key_pool[16];

    two_generation_aging_key_set u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    tgaks_scoreboard u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial cycles = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** two_generation_aging_key_set: FAILED **");
            $finish;
        end
    end

    // The receiver switches between always ready, random stalls and long stalls.
    always @(negedge clk)
    begin
        int mode;
        mode = (cycles / 3000) % 3;
        if (mode == 0)
            m_axis_tready <= 1'b1;
        else if (mode == 1)
            m_axis_tready <= $urandom_range(0, 1);
        else
            m_axis_tready <= ($urandom_range(0, 19) == 0);
    end

    task automatic send_request(cmd_t cmd, logic [63:0] hash, logic gossip);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end
        if (gap_left > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap_left) @(negedge clk);
            gap_left = 0;
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = hash;
        s_axis_tuser = {gossip, cmd};
        while (!s_axis_tready)
            @(negedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_limit(logic [8:0] value);
        drain();
        cfg_valid = 1'b1;
        cfg_data = value;
        while (!cfg_ready)
            @(negedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [63:0] pick_hash();
        if ($urandom_range(0, 9) == 0)
            return {$urandom, $urandom};
        return key_pool[$urandom_range(0, 15)] ^ 64'($urandom_range(0, 3));
    endfunction

    task automatic random_requests(int count, int add_pct, int age_pct);
        int roll;
        cmd_t cmd;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < add_pct)
                cmd = CMD_ADD;
            else if (roll < add_pct + age_pct)
                cmd = CMD_AGE;
            else if (roll < add_pct + age_pct + 2)
                cmd = CMD_NONE;
            else
                cmd = CMD_CHECK;
            send_request(cmd, pick_hash(), $urandom_range(0, 9) != 0);
        end
    endtask

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        burst_left = 0;
        gap_left = 0;
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        rst_n = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_request(CMD_ADD, 64'h0, 1'b1);
        send_request(CMD_ADD, 64'h3, 1'b1);
        send_request(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_request(CMD_ADD, key_pool[0], 1'b0);
        send_request(CMD_CHECK, key_pool[0], 1'b1);
        send_request(CMD_CHECK, 64'h1, 1'b1);
        send_request(CMD_CHECK, 64'h2, 1'b1);
        send_request(CMD_CHECK, 64'h0, 1'b1);
        send_request(CMD_CHECK, 64'hFFFF_FFFF_FFFF_FFFC, 1'b0);
        send_request(CMD_CHECK, 64'hFFFF_FFFF_FFFF_FFFC, 1'b1);
        send_request(CMD_ADD, key_pool[1], 1'b1);
        send_request(CMD_ADD, key_pool[1], 1'b1);
        send_request(CMD_AGE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_request(CMD_ADD, key_pool[1], 1'b1);
        send_request(CMD_CHECK, key_pool[1], 1'b1);
        send_request(CMD_CHECK, key_pool[1], 1'b1);
        send_request(CMD_CHECK, key_pool[1], 1'b1);
        send_request(CMD_CHECK, key_pool[1], 1'b1);
        send_request(CMD_NONE, key_pool[2], 1'b1);
        send_request(CMD_NONE, key_pool[2], 1'b0);
        send_request(CMD_AGE, 64'h0, 1'b1);
        send_request(CMD_CHECK, 64'h0, 1'b1);

        write_limit(9'd1);
        random_requests(150, 50, 5);
        write_limit(9'd511);
        random_requests(300, 90, 0);
        drain();
        random_requests(260, 90, 0);
        write_limit(9'd500);
        random_requests(520, 85, 0);
        for (int p = 0; p < 4; p++)
        begin
            write_limit(9'($urandom_range(2, 40)));
            random_requests(75, 50, 5);
        end

        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (2 * GEN_CAPACITY_DEFAULT + 16) @(negedge clk);
        if (errors == 0)
            $display("** two_generation_aging_key_set: PASSED **");
        else
            $display("** two_generation_aging_key_set: FAILED **");
        $finish;
    end

endmodule

/* files.f */
sv/tgaks_pkg.sv
sv/tgaks_cell.sv
sv/tgaks_ctrl.sv
sv/two_generation_aging_key_set.sv
sv/tgaks_checker.sv
test/tgaks_checker.sv
test/tb_top.sv
